@@ src/hrp_pkg.sv @@
package hrp_pkg;

  localparam int MAX_HEADER_SLOTS = 64;
  localparam int BODY_COUNT_BITS = 32;
  localparam int APB_ADDR_W = 3;
  localparam int MID_DEPTH = 2;

  localparam logic [5:0] HEADER_LIMIT_RESET = 6'd32;
  localparam logic [0:0] REG_HEADER_LIMIT = 1'b0;

  localparam logic [2:0] ROLE_METHOD = 3'd0;
  localparam logic [2:0] ROLE_URL = 3'd1;
  localparam logic [2:0] ROLE_VERSION = 3'd2;
  localparam logic [2:0] ROLE_KEY = 3'd3;
  localparam logic [2:0] ROLE_VALUE = 3'd4;
  localparam logic [2:0] ROLE_BODY = 3'd5;
  localparam logic [2:0] ROLE_DELIM = 3'd6;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
  localparam logic [2:0] ERR_BAD_LINE = 3'd2;
  localparam logic [2:0] ERR_BAD_METHOD = 3'd3;
  localparam logic [2:0] ERR_NO_COLON = 3'd4;
  localparam logic [2:0] ERR_NO_BLANK = 3'd5;

  localparam logic [1:0] METHOD_UNKNOWN = 2'd0;
  localparam logic [1:0] METHOD_GET = 2'd1;
  localparam logic [1:0] METHOD_POST = 2'd2;

  localparam logic [2:0] VERSION_UNKNOWN = 3'd0;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef struct packed {
    logic       is_end;
    logic       is_cr;
    logic       is_lf;
    logic       is_sp;
    logic       is_tab;
    logic       is_colon;
    logic [7:0] data;
  } cls_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_role;
    logic [5:0]  header_slot;
    logic        is_summary;
    logic        parse_ok;
    logic [2:0]  error_code;
    logic [1:0]  method_code;
    logic [2:0]  version_code;
    logic [5:0]  header_total;
    logic [31:0] body_length;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_pair_t;

  function automatic logic [7:0] get_char(logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = 8'h47;
      2'd1: c = 8'h45;
      2'd2: c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_char(logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = 8'h50;
      2'd1: c = 8'h4f;
      2'd2: c = 8'h53;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  // "HTTP/" then major digit, '.', minor digit
  function automatic logic [7:0] ver_char(logic [1:0] k, logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h48;
      3'd1: c = 8'h54;
      3'd2: c = 8'h54;
      3'd3: c = 8'h50;
      3'd4: c = 8'h2f;
      3'd5: c = (k == 2'd2) ? 8'h32 : ((k == 2'd3) ? 8'h33 : 8'h31);
      3'd6: c = 8'h2e;
      default: c = (k == 2'd1) ? 8'h31 : 8'h30;
    endcase
    return c;
  endfunction

endpackage

@@ src/hrp_in_if.sv @@
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

@@ src/hrp_out_if.sv @@
interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [2:0]  byte_role;
  logic [5:0]  header_slot;
  logic        is_summary;
  logic        parse_ok;
  logic [2:0]  error_code;
  logic [1:0]  method_code;
  logic [2:0]  version_code;
  logic [5:0]  header_total;
  logic [31:0] body_length;

  modport source (
    output valid, output byte_value, output byte_role, output header_slot,
    output is_summary, output parse_ok, output error_code, output method_code,
    output version_code, output header_total, output body_length, input ready
  );
  modport sink (
    input valid, input byte_value, input byte_role, input header_slot,
    input is_summary, input parse_ok, input error_code, input method_code,
    input version_code, input header_total, input body_length, output ready
  );
endinterface

@@ src/hrp_fifo.sv @@
module hrp_fifo #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             nempty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    count;

  assign full   = (count == CW'(DEPTH));
  assign nempty = (count != '0);
  assign rdata  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/hrp_front.sv @@
module hrp_front (
  hrp_in_if.sink        in_req,
  input  logic          q_full,
  output logic          q_push,
  output hrp_pkg::cls_t q_data
);

  assign in_req.ready = !q_full;
  assign q_push       = in_req.valid && !q_full;

  // a zero byte ends the request just as the end marker does
  always_comb begin
    q_data.data     = in_req.data_byte;
    q_data.is_end   = in_req.action || (in_req.data_byte == 8'h00);
    q_data.is_cr    = (in_req.data_byte == hrp_pkg::CH_CR);
    q_data.is_lf    = (in_req.data_byte == hrp_pkg::CH_LF);
    q_data.is_sp    = (in_req.data_byte == hrp_pkg::CH_SP);
    q_data.is_tab   = (in_req.data_byte == hrp_pkg::CH_TAB);
    q_data.is_colon = (in_req.data_byte == hrp_pkg::CH_COLON);
  end

endmodule

@@ src/hrp_back.sv @@
module hrp_back #(
  parameter int BODY_COUNT_BITS = hrp_pkg::BODY_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [5:0]        header_limit,
  input  logic              q_valid,
  input  hrp_pkg::cls_t     q_data,
  output logic              q_pop,
  input  logic              room,
  output hrp_pkg::res_pair_t push
);

  typedef enum logic [8:0] {
    PH_METHOD  = 9'b000000001,
    PH_URL     = 9'b000000010,
    PH_VERSION = 9'b000000100,
    PH_BADLINE = 9'b000001000,
    PH_KEY     = 9'b000010000,
    PH_VALUE   = 9'b000100000,
    PH_IGNORED = 9'b001000000,
    PH_BODY    = 9'b010000000,
    PH_ERROR   = 9'b100000000
  } phase_t;

  typedef struct packed {
    phase_t                     phase;
    logic                       held_cr;
    logic                       at_line_start;
    logic [3:0]                 fl;
    logic [1:0]                 mm;
    logic [3:0]                 vm;
    logic                       skipping;
    logic [5:0]                 hc;
    logic [1:0]                 bss;
    logic [BODY_COUNT_BITS-1:0] body;
    logic [2:0]                 err;
    logic [1:0]                 mres;
    logic [2:0]                 vres;
  } st_t;

  typedef struct packed {
    st_t           s;
    hrp_pkg::res_t r;
  } cstep_t;

  localparam logic [8:0] MAX_SLOTS = 9'(hrp_pkg::MAX_HEADER_SLOTS);

  function automatic st_t idle_state();
    st_t s;
    s               = '0;
    s.phase         = PH_METHOD;
    s.at_line_start = 1'b1;
    s.mm            = 2'b11;
    s.vm            = 4'b1111;
    return s;
  endfunction

  function automatic hrp_pkg::res_t byte_res(logic [7:0] v, logic [2:0] role,
                                            logic [5:0] slot);
    hrp_pkg::res_t r;
    r             = '0;
    r.byte_value  = v;
    r.byte_role   = role;
    r.header_slot = slot;
    return r;
  endfunction

  function automatic cstep_t content_f(st_t s_in, hrp_pkg::cls_t c, logic [8:0] lim);
    cstep_t o;
    logic   stop;
    o.s  = s_in;
    o.r  = byte_res(c.data, hrp_pkg::ROLE_DELIM, 6'd0);
    stop = 1'b0;
    unique case (s_in.phase)
      PH_METHOD: begin
        if (c.is_sp) begin
          if (s_in.fl == 4'd0) begin
            o.s.phase = PH_BADLINE;
            o.s.err   = hrp_pkg::ERR_BAD_LINE;
          end else begin
            if (s_in.fl != 4'd3) o.s.mm[0] = 1'b0;
            if (s_in.fl != 4'd4) o.s.mm[1] = 1'b0;
            o.s.phase = PH_URL;
            o.s.fl    = 4'd0;
          end
        end else begin
          if (s_in.fl >= 4'd3 || c.data != hrp_pkg::get_char(s_in.fl[1:0])) o.s.mm[0] = 1'b0;
          if (s_in.fl >= 4'd4 || c.data != hrp_pkg::post_char(s_in.fl[1:0])) o.s.mm[1] = 1'b0;
          if (s_in.fl < 4'd8) o.s.fl = s_in.fl + 1'b1;
          o.r.byte_role = hrp_pkg::ROLE_METHOD;
        end
      end
      PH_URL: begin
        if (c.is_sp) begin
          if (s_in.fl == 4'd0) begin
            o.s.phase = PH_BADLINE;
            o.s.err   = hrp_pkg::ERR_BAD_LINE;
          end else begin
            o.s.phase = PH_VERSION;
            o.s.fl    = 4'd0;
            o.s.vm    = 4'b1111;
          end
        end else begin
          if (s_in.fl < 4'd8) o.s.fl = s_in.fl + 1'b1;
          o.r.byte_role = hrp_pkg::ROLE_URL;
        end
      end
      PH_VERSION: begin
        if (s_in.fl < 4'd8) begin
          for (int k = 0; k < 4; k++) begin
            if (hrp_pkg::ver_char(2'(k), s_in.fl[2:0]) != c.data) o.s.vm[k] = 1'b0;
          end
          o.s.fl = s_in.fl + 1'b1;
        end
        o.r.byte_role = hrp_pkg::ROLE_VERSION;
      end
      PH_KEY: begin
        if (s_in.at_line_start) begin
          o.s.at_line_start = 1'b0;
          // past the limit: ignore the whole line
          if ({3'b000, s_in.hc} >= lim) begin
            o.s.phase = PH_IGNORED;
            stop      = 1'b1;
          end
        end
        if (!stop) begin
          if (c.is_colon) begin
            o.s.skipping = 1'b1;
            o.s.phase    = PH_VALUE;
          end else begin
            o.r = byte_res(c.data, hrp_pkg::ROLE_KEY, s_in.hc);
          end
        end
      end
      PH_VALUE: begin
        if (!(s_in.skipping && (c.is_sp || c.is_tab))) begin
          o.s.skipping = 1'b0;
          o.r          = byte_res(c.data, hrp_pkg::ROLE_VALUE, s_in.hc);
        end
      end
      PH_BODY: begin
        o.s.bss = 2'd0;
        if (s_in.body != '1) o.s.body = s_in.body + 1'b1;
        o.r.byte_role = hrp_pkg::ROLE_BODY;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic st_t line_end_f(st_t s_in, logic crlf);
    st_t s;
    s = s_in;
    unique case (s_in.phase) inside
      PH_METHOD, PH_URL, PH_BADLINE: begin
        s.phase = PH_ERROR;
        s.err   = hrp_pkg::ERR_BAD_LINE;
      end
      PH_VERSION: begin
        if (s_in.fl == 4'd0) begin
          s.phase = PH_ERROR;
          s.err   = hrp_pkg::ERR_BAD_LINE;
        end else if (s_in.mm == 2'b00) begin
          s.phase = PH_ERROR;
          s.err   = hrp_pkg::ERR_BAD_METHOD;
        end else begin
          s.mres = s_in.mm[0] ? hrp_pkg::METHOD_GET : hrp_pkg::METHOD_POST;
          s.vres = hrp_pkg::VERSION_UNKNOWN;
          // lowest matching candidate wins
          if (s_in.fl >= 4'd8) begin
            for (int k = 3; k >= 0; k--) begin
              if (s_in.vm[k]) s.vres = 3'(k + 1);
            end
          end
          s.phase         = PH_KEY;
          s.at_line_start = 1'b1;
        end
      end
      PH_KEY: begin
        if (s_in.at_line_start) begin
          s.phase = PH_BODY;
          s.bss   = crlf ? 2'd1 : 2'd2;
        end else begin
          s.phase = PH_ERROR;
          s.err   = hrp_pkg::ERR_NO_COLON;
        end
      end
      PH_VALUE: begin
        s.hc            = s_in.hc + 1'b1;
        s.skipping      = 1'b0;
        s.phase         = PH_KEY;
        s.at_line_start = 1'b1;
      end
      PH_IGNORED: begin
        s.phase         = PH_KEY;
        s.at_line_start = 1'b1;
      end
      PH_BODY: begin
        s.bss = 2'd0;
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  function automatic logic can_hold(st_t s);
    logic h;
    unique case (s.phase)
      PH_ERROR: h = 1'b0;
      PH_BODY:  h = (s.bss == 2'd1);
      default:  h = 1'b1;
    endcase
    return h;
  endfunction

  localparam hrp_pkg::cls_t CR_CLS = '{
    is_end: 1'b0, is_cr: 1'b1, is_lf: 1'b0, is_sp: 1'b0, is_tab: 1'b0,
    is_colon: 1'b0, data: hrp_pkg::CH_CR
  };

  st_t           st;
  st_t           st_next;
  logic [8:0]    lim_eff;
  logic          go;
  hrp_pkg::res_t res [2];
  logic [1:0]    n;

  assign go      = q_valid && room;
  assign q_pop   = go;
  assign lim_eff = ({3'b000, header_limit} > MAX_SLOTS) ? MAX_SLOTS : {3'b000, header_limit};

  always_comb begin
    st_t           s;
    cstep_t        cs;
    hrp_pkg::res_t sm;
    logic          done;
    logic [63:0]   body64;
    s      = st;
    cs     = '0;
    sm     = '0;
    done   = 1'b0;
    body64 = '0;
    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;
    if (q_data.is_end) begin
      // flush a held CR as an ordinary byte first
      if (s.held_cr) begin
        s.held_cr = 1'b0;
        cs        = content_f(s, CR_CLS, lim_eff);
        s         = cs.s;
        res[0]    = cs.r;
        n         = 2'd1;
      end
      body64          = 64'(s.body);
      sm.byte_role    = hrp_pkg::ROLE_DELIM;
      sm.is_summary   = 1'b1;
      sm.method_code  = s.mres;
      sm.version_code = s.vres;
      sm.header_total = s.hc;
      sm.body_length  = (body64[63:32] != 32'd0) ? 32'hffff_ffff : body64[31:0];
      if (s.phase == PH_BODY) begin
        sm.parse_ok   = 1'b1;
        sm.error_code = hrp_pkg::ERR_NONE;
      end else if (s.phase == PH_ERROR) begin
        sm.error_code = s.err;
      end else if (s.phase == PH_KEY && s.at_line_start) begin
        sm.error_code = hrp_pkg::ERR_NO_BLANK;
      end else begin
        sm.error_code = hrp_pkg::ERR_UNTERMINATED;
      end
      res[n[0]] = sm;
      n         = n + 1'b1;
      st_next   = idle_state();
    end else begin
      if (s.held_cr) begin
        s.held_cr = 1'b0;
        if (q_data.is_lf) begin
          res[0] = byte_res(hrp_pkg::CH_CR, hrp_pkg::ROLE_DELIM, 6'd0);
          s      = line_end_f(s, 1'b1);
          res[1] = byte_res(hrp_pkg::CH_LF, hrp_pkg::ROLE_DELIM, 6'd0);
          n      = 2'd2;
          done   = 1'b1;
        end else begin
          cs     = content_f(s, CR_CLS, lim_eff);
          s      = cs.s;
          res[0] = cs.r;
          n      = 2'd1;
        end
      end
      if (!done) begin
        if (q_data.is_cr && can_hold(s)) begin
          s.held_cr = 1'b1;
        end else if (q_data.is_lf && !(s.phase == PH_BODY && s.bss == 2'd0)) begin
          s         = line_end_f(s, 1'b0);
          res[n[0]] = byte_res(q_data.data, hrp_pkg::ROLE_DELIM, 6'd0);
          n         = n + 1'b1;
        end else begin
          cs        = content_f(s, q_data, lim_eff);
          s         = cs.s;
          res[n[0]] = cs.r;
          n         = n + 1'b1;
        end
      end
      st_next = s;
    end
  end

  always_comb begin
    push.count  = go ? n : 2'd0;
    push.first  = res[0];
    push.second = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= idle_state();
    end else if (go) begin
      st <= st_next;
    end
  end

endmodule

@@ src/hrp_obuf.sv @@
module hrp_obuf (
  input  logic               clk,
  input  logic               rst,
  input  hrp_pkg::res_pair_t push,
  output logic               room,
  hrp_out_if.source          out_res
);

  hrp_pkg::res_t mem [4];
  logic [1:0]    wp;
  logic [1:0]    rp;
  logic [2:0]    count;
  logic          pop;
  hrp_pkg::res_t head;

  // two free entries cover the worst case of one request
  assign room  = (count <= 3'd2);
  assign pop   = out_res.valid && out_res.ready;
  assign head  = mem[rp];

  assign out_res.valid        = (count != 3'd0);
  assign out_res.byte_value   = head.byte_value;
  assign out_res.byte_role    = head.byte_role;
  assign out_res.header_slot  = head.header_slot;
  assign out_res.is_summary   = head.is_summary;
  assign out_res.parse_ok     = head.parse_ok;
  assign out_res.error_code   = head.error_code;
  assign out_res.method_code  = head.method_code;
  assign out_res.version_code = head.version_code;
  assign out_res.header_total = head.header_total;
  assign out_res.body_length  = head.body_length;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wp + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.count;
      rp    <= rp + {1'b0, pop};
      count <= count + {1'b0, push.count} - {2'b00, pop};
    end
  end

endmodule

@@ src/http_request_head_parser_top.sv @@
// A result goes from the byte queue through the parser to the output buffer. One byte
// per cycle enters while the queue has space; the parser takes one per cycle from
// its queue when the output buffer has room. A held CR produces no result; the next
// byte may give two; the 4-entry output buffer drains one per cycle on out_res.ready.
// Reset (rst, synchronous): queues empty, parser idle, header_limit back to 32.
module http_request_head_parser_top #(
  parameter int BODY_COUNT_BITS = hrp_pkg::BODY_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  hrp_in_if.sink                         in_req,
  hrp_out_if.source                      out_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int CLS_W = $bits(hrp_pkg::cls_t);

  logic               header_limit;
  logic [5:0]         limit_reg;
  logic               q_full;
  logic               q_push;
  hrp_pkg::cls_t      q_wdata;
  logic               q_nempty;
  logic               q_pop;
  logic [CLS_W-1:0]   q_rdata;
  logic               room;
  hrp_pkg::res_pair_t push;

  assign pready       = 1'b1;
  assign header_limit = (paddr[2] == hrp_pkg::REG_HEADER_LIMIT);
  assign prdata       = header_limit ? {26'd0, limit_reg} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= hrp_pkg::HEADER_LIMIT_RESET;
    end else if (psel && penable && pwrite && header_limit) begin
      limit_reg <= pwdata[5:0];
    end
  end

  hrp_front u_front (
    .in_req (in_req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  hrp_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (hrp_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .nempty (q_nempty),
    .rdata  (q_rdata)
  );

  hrp_back #(
    .BODY_COUNT_BITS (BODY_COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .header_limit (limit_reg),
    .q_valid      (q_nempty),
    .q_data       (hrp_pkg::cls_t'(q_rdata)),
    .q_pop        (q_pop),
    .room         (room),
    .push         (push)
  );

  hrp_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .out_res (out_res)
  );

endmodule

@@ tb/sv/tb_http_request_head_parser_top.sv @@
module tb_http_request_head_parser_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hrp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEGMENT_ITEMS = 120;
  localparam logic [APB_ADDR_W-1:0] HDR_LIMIT_ADDR = APB_ADDR_W'(4 * REG_HEADER_LIMIT);
  localparam logic [23:0] GET_WORD = "GET";
  localparam logic [31:0] POST_WORD = "POST";

  typedef enum logic [3:0] {
    PH_METHOD, PH_URL, PH_VERSION, PH_BADLINE, PH_KEY,
    PH_VALUE, PH_IGNORED, PH_BODY, PH_ERROR
  } parse_phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } req_item_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hrp_in_if  in_req ();
  hrp_out_if out_res ();

  http_request_head_parser_top DUT (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req),
    .out_res (out_res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  req_item_t  req_queue[$];
  res_t       byte_tags[$];
  logic [7:0] draft[$];

  int  src_idle_pct;
  int  sink_idle_pct;
  bit  req_taken;
  int  cycle_count;
  int  fail_count;
  int  items_sent;
  int  results_checked;
  int  requests_checked;
  res_t head_tag;

  // parser mirror
  parse_phase_t ph;
  bit          cr_held;
  bit          line_start;
  logic [3:0]  fld_len;
  logic [1:0]  meth_cand;   // bit 0 GET, bit 1 POST
  logic [3:0]  ver_cand;
  bit          skip_ws;
  logic [5:0]  hdr_count;
  logic [1:0]  blank_skip;
  logic [31:0] body_cnt;
  logic [2:0]  err_latched;
  logic [1:0]  meth_res;
  logic [2:0]  ver_res;
  logic [5:0]  hdr_limit;

  function automatic logic [63:0] version_text(int k);
    case (k)
      0: return "HTTP/1.0";
      1: return "HTTP/1.1";
      2: return "HTTP/2.0";
      default: return "HTTP/3.0";
    endcase
  endfunction

  function automatic void emit_tag(logic [7:0] v, logic [2:0] role, logic [5:0] slot);
    res_t t;
    t = '0;
    t.byte_value = v;
    t.byte_role = role;
    t.header_slot = slot;
    byte_tags.push_back(t);
  endfunction

  function automatic void clear_request();
    ph = PH_METHOD;
    cr_held = 0;
    line_start = 1;
    fld_len = '0;
    meth_cand = 2'b11;
    ver_cand = 4'hf;
    skip_ws = 0;
    hdr_count = '0;
    blank_skip = '0;
    body_cnt = '0;
    err_latched = ERR_NONE;
    meth_res = METHOD_UNKNOWN;
    ver_res = VERSION_UNKNOWN;
  endfunction

  function automatic void tag_content(logic [7:0] c);
    int i;
    bit over_limit;
    logic [63:0] vt;
    i = fld_len;
    case (ph)
      PH_METHOD: begin
        if (c == CH_SP) begin
          if (i == 0) begin
            ph = PH_BADLINE;
            err_latched = ERR_BAD_LINE;
          end else begin
            if (i != 3) meth_cand[0] = 0;
            if (i != 4) meth_cand[1] = 0;
            ph = PH_URL;
            fld_len = '0;
          end
          emit_tag(c, ROLE_DELIM, '0);
        end else begin
          if (i >= 3 || c != GET_WORD[23 - 8 * i -: 8]) meth_cand[0] = 0;
          if (i >= 4 || c != POST_WORD[31 - 8 * i -: 8]) meth_cand[1] = 0;
          if (fld_len < 8) fld_len++;
          emit_tag(c, ROLE_METHOD, '0);
        end
      end
      PH_URL: begin
        if (c == CH_SP) begin
          if (i == 0) begin
            ph = PH_BADLINE;
            err_latched = ERR_BAD_LINE;
          end else begin
            ph = PH_VERSION;
            fld_len = '0;
            ver_cand = 4'hf;
          end
          emit_tag(c, ROLE_DELIM, '0);
        end else begin
          if (fld_len < 8) fld_len++;
          emit_tag(c, ROLE_URL, '0);
        end
      end
      PH_VERSION: begin
        if (i < 8) begin
          for (int k = 0; k < 4; k++) begin
            vt = version_text(k);
            if (vt[63 - 8 * i -: 8] != c) ver_cand[k] = 0;
          end
          fld_len++;
        end
        emit_tag(c, ROLE_VERSION, '0);
      end
      PH_KEY: begin
        over_limit = line_start && (hdr_count >= hdr_limit);
        line_start = 0;
        if (over_limit) begin
          ph = PH_IGNORED;
          emit_tag(c, ROLE_DELIM, '0);
        end else if (c == CH_COLON) begin
          skip_ws = 1;
          ph = PH_VALUE;
          emit_tag(c, ROLE_DELIM, '0);
        end else begin
          emit_tag(c, ROLE_KEY, hdr_count);
        end
      end
      PH_VALUE: begin
        if (skip_ws && (c == CH_SP || c == CH_TAB)) begin
          emit_tag(c, ROLE_DELIM, '0);
        end else begin
          skip_ws = 0;
          emit_tag(c, ROLE_VALUE, hdr_count);
        end
      end
      PH_BODY: begin
        blank_skip = '0;
        if (body_cnt != '1) body_cnt++;
        emit_tag(c, ROLE_BODY, '0);
      end
      default: emit_tag(c, ROLE_DELIM, '0);
    endcase
  endfunction

  function automatic void tag_line_end(bit crlf);
    case (ph) inside
      PH_METHOD, PH_URL, PH_BADLINE: begin
        ph = PH_ERROR;
        err_latched = ERR_BAD_LINE;
      end
      PH_VERSION: begin
        if (fld_len == 0) begin
          ph = PH_ERROR;
          err_latched = ERR_BAD_LINE;
        end else if (meth_cand == 0) begin
          ph = PH_ERROR;
          err_latched = ERR_BAD_METHOD;
        end else begin
          meth_res = meth_cand[0] ? METHOD_GET : METHOD_POST;
          ver_res = VERSION_UNKNOWN;
          // first surviving candidate wins, only on a full 8-byte match
          if (fld_len >= 8)
            for (int k = 3; k >= 0; k--)
              if (ver_cand[k]) ver_res = 3'(k + 1);
          ph = PH_KEY;
          line_start = 1;
        end
      end
      PH_KEY: begin
        if (line_start) begin
          ph = PH_BODY;
          blank_skip = crlf ? 2'd1 : 2'd2;
        end else begin
          ph = PH_ERROR;
          err_latched = ERR_NO_COLON;
        end
      end
      PH_VALUE: begin
        hdr_count++;
        skip_ws = 0;
        ph = PH_KEY;
        line_start = 1;
      end
      PH_IGNORED: begin
        ph = PH_KEY;
        line_start = 1;
      end
      PH_BODY: blank_skip = '0;
      default: ;
    endcase
  endfunction

  function automatic void parse_request_byte(logic action, logic [7:0] b);
    res_t t;
    bit ok;
    logic [2:0] code;
    if (action || b == 8'h00) begin
      if (cr_held) begin
        cr_held = 0;
        tag_content(CH_CR);
      end
      ok = 0;
      if (ph == PH_BODY) begin
        ok = 1;
        code = ERR_NONE;
      end else if (ph == PH_ERROR) begin
        code = err_latched;
      end else if (ph == PH_KEY && line_start) begin
        code = ERR_NO_BLANK;
      end else begin
        code = ERR_UNTERMINATED;
      end
      t = '0;
      t.byte_role = ROLE_DELIM;
      t.is_summary = 1;
      t.parse_ok = ok;
      t.error_code = code;
      t.method_code = meth_res;
      t.version_code = ver_res;
      t.header_total = hdr_count;
      t.body_length = body_cnt;
      byte_tags.push_back(t);
      clear_request();
      return;
    end
    if (cr_held) begin
      cr_held = 0;
      if (b == CH_LF) begin
        emit_tag(CH_CR, ROLE_DELIM, '0);
        tag_line_end(1);
        emit_tag(CH_LF, ROLE_DELIM, '0);
        return;
      end
      tag_content(CH_CR);
    end
    if (b == CH_CR && ph != PH_ERROR && (ph != PH_BODY || blank_skip == 1)) begin
      cr_held = 1;
      return;
    end
    if (b == CH_LF) begin
      if (ph == PH_BODY && blank_skip == 0) begin
        tag_content(b);
      end else begin
        tag_line_end(0);
        emit_tag(b, ROLE_DELIM, '0);
      end
      return;
    end
    tag_content(b);
  endfunction

  // stimulus building
  function automatic void push_item(logic a, logic [7:0] d);
    req_item_t it;
    it.action = a;
    it.data = d;
    req_queue.push_back(it);
    items_sent++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endfunction

  function automatic void add_token(int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(33, 126));
      if (c == CH_COLON) c = "-";
      draft.push_back(c);
    end
  endfunction

  function automatic void add_eol();
    if ($urandom_range(1)) draft.push_back(CH_CR);
    draft.push_back(CH_LF);
  endfunction

  function automatic void send_draft(int keep);
    for (int i = 0; i < keep; i++) push_item(1'b0, draft[i]);
    draft.delete();
  endfunction

  function automatic void build_request();
    int r;
    int n_hdr;
    int keep;
    logic [7:0] v;
    draft.delete();
    if ($urandom_range(99) < 8) begin
      // noise
      repeat ($urandom_range(1, 20)) draft.push_back(8'($urandom_range(1, 255)));
    end else begin
      r = $urandom_range(99);
      if (r < 40) add_text("GET");
      else if (r < 75) add_text("POST");
      else if (r < 82) add_text("GETS");
      else if (r < 88) add_text("POS");
      else if (r < 95) add_token($urandom_range(1, 5));
      if ($urandom_range(99) >= 4) draft.push_back(CH_SP);
      if ($urandom_range(99) >= 5) begin
        add_text("/");
        add_token($urandom_range(0, 5));
      end
      if ($urandom_range(99) >= 4) draft.push_back(CH_SP);
      r = $urandom_range(99);
      if (r < 70) begin
        case ($urandom_range(3))
          0: add_text("HTTP/1.0");
          1: add_text("HTTP/1.1");
          2: add_text("HTTP/2.0");
          default: add_text("HTTP/3.0");
        endcase
      end
      else if (r < 78) add_text("HTTP/1.2");
      else if (r < 84) add_text("HTTP/1.10");
      else if (r < 88) add_text("HTTP");
      else if (r < 92) add_text("HTTP 1.1");
      else if (r < 96) add_token($urandom_range(1, 10));
      add_eol();
      n_hdr = ($urandom_range(99) < 12) ? $urandom_range(3, 8) : $urandom_range(0, 3);
      repeat (n_hdr) begin
        if ($urandom_range(99) >= 5) add_token($urandom_range(1, 6));
        if ($urandom_range(99) >= 5) draft.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) draft.push_back($urandom_range(1) ? CH_SP : CH_TAB);
        repeat ($urandom_range(0, 6)) begin
          v = 8'($urandom_range(1, 255));
          if (v == CH_LF) v = "~";
          draft.push_back(v);
        end
        add_eol();
      end
      if ($urandom_range(99) < 92) add_eol();
      if ($urandom_range(99) < 35) add_eol();
      repeat ($urandom_range(0, 8)) draft.push_back(8'($urandom_range(1, 255)));
    end
    // cut some requests short
    keep = ($urandom_range(99) < 8) ? $urandom_range(0, draft.size()) : draft.size();
    send_draft(keep);
    if ($urandom_range(1)) push_item(1'b1, 8'($urandom_range(255)));
    else push_item(1'b0, 8'h00);
  endfunction

  task automatic settle();
    do @(posedge clk); while (req_queue.size() != 0 || byte_tags.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_header_limit(logic [5:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= HDR_LIMIT_ADDR;
    pwdata <= {26'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    hdr_limit = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {26'b0, v}) begin
      $error("header_limit readback: expected %0d, actual %0d", v, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_segment(logic [5:0] limit, int src_idle, int sink_idle);
    int start_items;
    set_header_limit(limit);
    src_idle_pct = src_idle;
    sink_idle_pct = sink_idle;
    start_items = items_sent;
    while (items_sent - start_items < SEGMENT_ITEMS) build_request();
    settle();
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // accept side: predict on each accepted request
  always @(posedge clk) begin
    req_taken <= !rst && in_req.valid && in_req.ready;
    if (!rst && in_req.valid && in_req.ready) begin
      parse_request_byte(in_req.action, in_req.data_byte);
      void'(req_queue.pop_front());
    end
  end

  // request driver: hold an offered request until taken
  always @(negedge clk) begin
    if (rst) begin
      in_req.valid <= 1'b0;
    end else if (!(in_req.valid && !req_taken)) begin
      if (req_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_req.valid <= 1'b1;
        in_req.action <= req_queue[0].action;
        in_req.data_byte <= req_queue[0].data;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_res.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_res.valid && out_res.ready) begin
      if (byte_tags.size() == 0) begin
        $error("result with none pending: byte_value %0d role %0d",
               out_res.byte_value, out_res.byte_role);
        fail_count++;
      end else begin
        head_tag = byte_tags.pop_front();
        check_field("byte_value", head_tag.byte_value, out_res.byte_value);
        check_field("byte_role", head_tag.byte_role, out_res.byte_role);
        check_field("header_slot", head_tag.header_slot, out_res.header_slot);
        check_field("is_summary", head_tag.is_summary, out_res.is_summary);
        check_field("parse_ok", head_tag.parse_ok, out_res.parse_ok);
        check_field("error_code", head_tag.error_code, out_res.error_code);
        check_field("method_code", head_tag.method_code, out_res.method_code);
        check_field("version_code", head_tag.version_code, out_res.version_code);
        check_field("header_total", head_tag.header_total, out_res.header_total);
        check_field("body_length", head_tag.body_length, out_res.body_length);
        results_checked++;
        if (head_tag.is_summary) requests_checked++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_req.valid = 1'b0;
    in_req.action = 1'b0;
    in_req.data_byte = 8'h00;
    out_res.ready = 1'b0;
    req_taken = 1'b0;
    cycle_count = 0;
    fail_count = 0;
    items_sent = 0;
    results_checked = 0;
    requests_checked = 0;
    src_idle_pct = 19;
    sink_idle_pct = 76;
    hdr_limit = HEADER_LIMIT_RESET;
    clear_request();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: bare end, empty method, clean GET with lone CR in the URL,
    // blank-line skip and one body byte closed by a zero byte
    push_item(1'b1, 8'hff);
    add_text(" ");
    draft.push_back(CH_LF);
    send_draft(draft.size());
    push_item(1'b0, 8'h00);
    add_text("GET /");
    draft.push_back(CH_CR);
    add_text(" HTTP/1.1");
    repeat (3) begin
      draft.push_back(CH_CR);
      draft.push_back(CH_LF);
    end
    draft.push_back(8'hff);
    send_draft(draft.size());
    push_item(1'b0, 8'h00);
    settle();

    run_segment(6'd0, 19, 76);
    run_segment(6'd63, 19, 76);
    run_segment(6'd1, 76, 19);
    run_segment(6'd2, 76, 19);
    run_segment(HEADER_LIMIT_RESET, 0, 0);
    run_segment(6'($urandom_range(63)), 0, 0);

    $display("Sent %0d request bytes and ends; checked %0d results over %0d requests",
             items_sent, results_checked, requests_checked);
    $display("with header limits 0, 1, 2, 32, 63 and one random value, under mixed stalls.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
